// ===== src/bclpd_pkg.sv =====
// Shared types and constants for the button click and long-press detector.
`timescale 1ns / 1ps

package bclpd_pkg;

  localparam int unsigned NumButtonsDef = 2;
  localparam int unsigned PinW          = 2;
  localparam int unsigned IdW           = 2;
  localparam int unsigned CfgW          = 16;
  localparam int unsigned TimeW         = 32;
  localparam logic [CfgW-1:0] LongPressReset = 16'd3000;

  typedef enum logic [1:0] {
    ACT_SCAN       = 2'd0,
    ACT_TAKE_CLICK = 2'd1,
    ACT_TAKE_LONG  = 2'd2,
    ACT_INIT       = 2'd3
  } bclpd_action_e;

  typedef struct packed {
    bclpd_action_e    action;
    logic [PinW-1:0]  pin_levels;
    logic [TimeW-1:0] now_ms;
    logic [IdW-1:0]   button_id;
  } bclpd_in_t;

  typedef struct packed {
    logic            event_taken;
    logic [PinW-1:0] held_levels;
    logic [PinW-1:0] clicks_pending;
    logic [PinW-1:0] longs_pending;
  } bclpd_out_t;

  // Per-button command, broadcast from the input register.
  typedef struct packed {
    logic             fire;
    bclpd_action_e    action;
    logic             pin;
    logic             sel;
    logic [TimeW-1:0] now_ms;
  } bclpd_cmd_t;

  // Per-button state after the beat, plus the take result.
  typedef struct packed {
    logic level;
    logic click;
    logic lng;
    logic taken;
  } bclpd_stat_t;

endpackage

// ===== src/button_click_long_press_detector.sv =====
// Button click and long-press detector: input register, per-button cells, result register.
// A beat accepted into the input register moves on into the result register once that register is free.
// Throughput: one item per cycle while out_stall_i is low; the per-button compare is a single 32-bit subtract.
// Result register and input register each hold one beat, so one more input beat is taken while a
// result waits. Reset clears all levels and flags and sets long_press_ms to 3000.
`timescale 1ns / 1ps

module button_click_long_press_detector import bclpd_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bclpd_in_t       in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bclpd_out_t      out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic                        in_valid_q;
  bclpd_in_t                   in_data_q;
  logic                        out_valid_q;
  bclpd_out_t                  out_data_q, out_data_d;
  logic [CfgW-1:0]             long_press_q;
  logic                        out_ready, fire, in_load;
  bclpd_stat_t [NUM_BUTTONS-1:0] stat;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & out_ready;
  assign in_load    = ~in_valid_q | fire;
  assign in_stall_o = ~in_load;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      long_press_q <= LongPressReset;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= fire;
      end
      if (cfg_valid_i) begin
        long_press_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    bclpd_cmd_t cmd;
    logic       pin;

    if (i < PinW) begin : g_pin
      assign pin = in_data_q.pin_levels[i];
    end else begin : g_nopin
      // buttons beyond the pin field always sample released
      assign pin = 1'b0;
    end

    assign cmd = '{fire:   fire,
                   action: in_data_q.action,
                   pin:    pin,
                   sel:    ({{(32-IdW){1'b0}}, in_data_q.button_id} == 32'(i + 1)),
                   now_ms: in_data_q.now_ms};

    bclpd_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .long_press_ms_i(long_press_q),
      .stat_o         (stat[i])
    );
  end

  always_comb begin
    out_data_d = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      out_data_d.event_taken = out_data_d.event_taken | stat[i].taken;
    end
    for (int i = 0; i < PinW; i++) begin
      if (i < NUM_BUTTONS) begin
        out_data_d.held_levels[i]    = stat[i].level;
        out_data_d.clicks_pending[i] = stat[i].click;
        out_data_d.longs_pending[i]  = stat[i].lng;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_scan_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_data_q.action == ACT_SCAN || in_data_q.action == ACT_INIT)
    |=> !out_data_o.event_taken)
    else $error("event_taken set on scan or init beat");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_data_q.action == ACT_INIT)
    |=> (out_data_o.clicks_pending == '0) && (out_data_o.longs_pending == '0))
    else $error("init beat left a pending flag");

  a_click_long_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.clicks_pending & out_data_o.longs_pending) == '0))
    else $error("click and long press pending on the same button");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while both stages are full");
`endif

endmodule

// ===== src/bclpd_cell.sv =====
// One button: edge detection, hold timer compare and pending event flags.
`timescale 1ns / 1ps

module bclpd_cell import bclpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bclpd_cmd_t       cmd_i,
  input  logic [CfgW-1:0]  long_press_ms_i,
  output bclpd_stat_t      stat_o
);

  logic             level_q, level_d;
  logic             hold_q, hold_d;
  logic             click_q, click_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             rise, fall, taken;
  logic [TimeW-1:0] elapsed;

  assign rise    = cmd_i.pin & ~level_q;
  assign fall    = ~cmd_i.pin & level_q;
  assign start_d = rise ? cmd_i.now_ms : start_q;
  assign elapsed = cmd_i.now_ms - start_d;

  always_comb begin
    level_d = level_q;
    hold_d  = hold_q;
    click_d = click_q;
    long_d  = long_q;
    taken   = 1'b0;
    if (cmd_i.fire) begin
      unique case (cmd_i.action)
        ACT_SCAN: begin
          if (rise) begin
            hold_d  = 1'b1;
            click_d = 1'b0;
            long_d  = 1'b0;
          end else if (fall) begin
            hold_d = 1'b0;
            if (!long_q) begin
              click_d = 1'b1;
            end
          end
          if (hold_d && !long_d && (elapsed >= {{(TimeW-CfgW){1'b0}}, long_press_ms_i})) begin
            long_d  = 1'b1;
            click_d = 1'b0;
          end
          level_d = cmd_i.pin;
        end
        ACT_TAKE_CLICK: begin
          if (cmd_i.sel && click_q) begin
            click_d = 1'b0;
            taken   = 1'b1;
          end
        end
        ACT_TAKE_LONG: begin
          if (cmd_i.sel && long_q) begin
            long_d = 1'b0;
            taken  = 1'b1;
          end
        end
        ACT_INIT: begin
          level_d = cmd_i.pin;
          hold_d  = 1'b0;
          click_d = 1'b0;
          long_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      hold_q  <= 1'b0;
      click_q <= 1'b0;
      long_q  <= 1'b0;
    end else begin
      level_q <= level_d;
      hold_q  <= hold_d;
      click_q <= click_d;
      long_q  <= long_d;
    end
  end

  // Start time is only read while holding, and holding is only set together with it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire && (cmd_i.action == ACT_SCAN) && rise) begin
      start_q <= start_d;
    end
  end

  assign stat_o = '{level: level_d, click: click_d, lng: long_d, taken: taken};

endmodule
